// ===== src/modbus_holding_register_server_assert.svh =====
// assertion macros for the holding register server checker
`ifndef MODBUS_HOLDING_REGISTER_SERVER_ASSERT_SVH
`define MODBUS_HOLDING_REGISTER_SERVER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MHRS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define MHRS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== src/mhrs_pkg.sv =====
// shared constants and types of the holding register server
`default_nettype none
package mhrs_pkg;
    localparam logic [7:0] FC_READ_HOLD  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT = 8'h04;
    localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FC_WRITE_MANY = 8'h10;
    localparam logic [7:0] EXC_FUNCTION  = 8'h01;
    localparam logic [7:0] EXC_ADDRESS   = 8'h02;
    localparam logic [7:0] EXC_VALUE     = 8'h03;
    localparam logic [7:0] EXC_FLAG      = 8'h80;
    localparam logic [15:0] READ_MAX     = 16'd125;
    localparam logic [15:0] WRITE_MAX    = 16'd123;
    localparam logic [15:0] REG_BASE     = 16'h1000;

    // bank port request from the sequencer
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [3:0] addr;
        logic [15:0] wdata;
    } t_bank_req;
endpackage
`default_nettype wire

// ===== src/mhrs_bank.sv =====
// holding register memory with an init pass after reset that loads REG_BASE plus the index
`default_nettype none
module mhrs_bank #(
    parameter int REG_COUNT = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire mhrs_pkg::t_bank_req i_req,
    output logic [15:0]      o_rdata,
    output logic             o_ready
);
    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    logic [15:0] r_mem [REG_COUNT];
    logic [AW:0] r_clr;
    logic        r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_init <= 1'b1;
        end else if (r_init) begin
            if (r_clr == (AW+1)'(REG_COUNT - 1)) begin
                r_init <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init) begin
            r_mem[r_clr[AW-1:0]] <= mhrs_pkg::REG_BASE + 16'(r_clr);
        end else if (i_req.wr) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.rd) begin
            o_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_ready = !r_init;
endmodule
`default_nettype wire

// ===== src/mhrs_buf.sv =====
// frame byte store: header and write data in one memory
`default_nettype none
module mhrs_buf (
    input  wire        i_clk,
    input  wire        i_we,
    input  wire [5:0]  i_waddr,
    input  wire [7:0]  i_wdata,
    input  wire        i_re,
    input  wire [5:0]  i_raddr,
    output logic [7:0] o_rdata
);
    logic [7:0] r_mem [38];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/modbus_holding_register_server.sv =====
// top level of the modbus holding register server
//
// channel | dir | tdata fields (low bit up)               | tlast       | tuser
// s_axis  | in  | frame_address, byte_present, pdu_byte   | pdu_last    | action
// m_axis  | out | reply_address, reply_byte               | reply_last  | -
// cfg     | in  | own_address (write enable + data)       | -           | -
//
// bytes that do not end a frame can come back to back, one per cycle, once the
// bank is ready; a tick is accepted, then register 0 gets the uptime; a frame end
// for another address is accepted, then the uptime copy is written
// an own or broadcast frame end runs the header reads, the judge step, one bank
// write for write single or the WRD, WRL and WRW states per register for write
// multiple, the reply header bytes, the RDR, RDH and RDL states per register read,
// then INC, INCW and UPT to bump register 1 and copy the uptime; each reply byte
// waits for the master side, and after reset an init pass loads the bank
`default_nettype none
module modbus_holding_register_server #(
    parameter int REG_COUNT = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] frame_address, [8] byte_present, [16:9] pdu_byte, [23:17] zero
    input  wire  [23:0] s_axis_tdata,
    input  wire         s_axis_tlast,
    // [0] action
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] reply_address, [15:8] reply_byte
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_wdata
);
    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0,  S_TICK = 4'd1,  S_HDR  = 4'd2,
                           S_JUDGE = 4'd3, S_WRD  = 4'd4,  S_WRL  = 4'd5,
                           S_WRW  = 4'd6,  S_RDR  = 4'd7,  S_RDH  = 4'd8,
                           S_RDL  = 4'd9,  S_EMIT = 4'd10, S_INC  = 4'd11,
                           S_INCW = 4'd12, S_UPT  = 4'd13, S_SEND = 4'd14;

    logic [3:0]  r_st;
    logic [7:0]  r_own, r_len;
    logic [15:0] r_up;
    logic [7:0]  r_hdr [6];
    logic [2:0]  r_hcnt;
    logic [7:0]  r_idx;
    logic [7:0]  r_tx [5];
    logic [2:0]  r_txn, r_txk;
    logic [7:0]  r_lo_byte;
    logic        r_mv;
    logic [7:0]  r_md;
    logic        r_ml;
    logic        r_rd_last;
    logic        r_reply;

    mhrs_pkg::t_bank_req w_req;
    logic [15:0] w_bank_rd;
    logic        w_bank_ok;
    logic        w_buf_we, w_buf_re;
    logic [5:0]  w_buf_wa, w_buf_ra;
    logic [7:0]  w_buf_rd;

    logic        w_acc, w_tick, w_bp, w_last;
    logic [7:0]  w_fa, w_pb, w_fc;
    logic [15:0] w_start, w_count;
    logic [16:0] w_end;
    logic        w_out_free;

    mhrs_bank #(.REG_COUNT(REG_COUNT)) u_bank (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .o_rdata(w_bank_rd), .o_ready(w_bank_ok)
    );

    mhrs_buf u_buf (
        .i_clk(i_clk), .i_we(w_buf_we), .i_waddr(w_buf_wa), .i_wdata(w_pb),
        .i_re(w_buf_re), .i_raddr(w_buf_ra), .o_rdata(w_buf_rd)
    );

    assign w_fa   = s_axis_tdata[7:0];
    assign w_bp   = s_axis_tdata[8];
    assign w_pb   = s_axis_tdata[16:9];
    assign w_last = s_axis_tlast;
    assign w_tick = s_axis_tuser;
    assign s_axis_tready = (r_st == S_IDLE) && w_bank_ok;
    assign w_acc  = s_axis_tvalid && s_axis_tready;

    // bytes are stored at their frame position while below 38
    assign w_buf_we = w_acc && !w_tick && w_bp && (r_len < 8'd38);
    assign w_buf_wa = r_len[5:0];

    assign w_fc    = r_hdr[0];
    assign w_start = {r_hdr[1], r_hdr[2]};
    assign w_count = {r_hdr[3], r_hdr[4]};
    assign w_end   = {1'b0, w_start} + {1'b0, w_count};
    assign w_out_free = !r_mv || m_axis_tready;

    // header fetch and write data reads share the buffer read port
    always_comb begin
        w_buf_re = 1'b0;
        w_buf_ra = '0;
        if (r_st == S_HDR) begin
            w_buf_re = 1'b1;
            w_buf_ra = {3'd0, r_hcnt};
        end else if (r_st == S_WRD) begin
            w_buf_re = 1'b1;
            w_buf_ra = 6'(8'd6 + {r_idx[6:0], 1'b0});
        end else if (r_st == S_WRL) begin
            w_buf_re = 1'b1;
            w_buf_ra = 6'(8'd7 + {r_idx[6:0], 1'b0});
        end
    end

    always_comb begin
        w_req = '0;
        case (r_st)
            S_TICK: begin
                w_req.wr = 1'b1; w_req.addr = 4'd0; w_req.wdata = r_up;
            end
            S_UPT: begin
                w_req.wr = 1'b1; w_req.addr = 4'd0; w_req.wdata = r_up;
            end
            S_WRW: begin
                // single write takes the value from the header
                w_req.wr = 1'b1;
                w_req.addr = 4'(w_start + 16'(r_idx));
                w_req.wdata = (w_fc == mhrs_pkg::FC_WRITE_ONE) ? w_count :
                              {r_lo_byte, w_buf_rd};
            end
            S_RDR: begin
                w_req.rd = 1'b1; w_req.addr = 4'(w_start + 16'(r_idx));
            end
            S_INC: begin
                w_req.rd = 1'b1; w_req.addr = 4'd1;
            end
            S_INCW: begin
                w_req.wr = 1'b1; w_req.addr = 4'd1; w_req.wdata = w_bank_rd + 16'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_own <= 8'd1;
            r_len <= '0;
            r_up  <= '0;
            r_mv  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_own <= i_cfg_wdata;
            end
            if (r_mv && m_axis_tready) begin
                r_mv <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (w_acc) begin
                        if (w_tick) begin
                            r_up <= r_up + 16'd1;
                            r_st <= S_TICK;
                        end else if (w_last) begin
                            r_reply <= (w_fa == r_own) && (w_fa != 8'd0);
                            r_hcnt  <= '0;
                            if (w_fa == r_own || w_fa == 8'd0) begin
                                if (w_bp && r_len != 8'hFF) begin
                                    r_len <= r_len + 8'd1;
                                end
                                r_st <= S_HDR;
                            end else begin
                                // foreign frame: drop it, only the uptime copy
                                r_len <= '0;
                                r_st  <= S_UPT;
                            end
                        end else if (w_bp && r_len != 8'hFF) begin
                            r_len <= r_len + 8'd1;
                        end
                    end
                end
                S_TICK: r_st <= S_IDLE;
                S_HDR: begin
                    // buffer data is registered, so it arrives in the cycle after its address
                    if (r_hcnt != 3'd0) begin
                        r_hdr[r_hcnt - 3'd1] <= w_buf_rd;
                    end
                    if (r_hcnt == 3'd6) begin
                        r_st <= S_JUDGE;
                    end
                    r_hcnt <= r_hcnt + 3'd1;
                end
                S_JUDGE: begin
                    r_txk <= '0;
                    r_idx <= '0;
                    r_txn <= 3'd2;
                    r_tx[0] <= w_fc | mhrs_pkg::EXC_FLAG;
                    r_st <= S_EMIT;
                    if (r_len == 8'd0) begin
                        r_txn <= 3'd0;
                    end else if (w_fc != mhrs_pkg::FC_READ_HOLD &&
                                 w_fc != mhrs_pkg::FC_READ_INPUT &&
                                 w_fc != mhrs_pkg::FC_WRITE_ONE &&
                                 w_fc != mhrs_pkg::FC_WRITE_MANY) begin
                        r_tx[1] <= mhrs_pkg::EXC_FUNCTION;
                    end else if (r_len < ((w_fc == mhrs_pkg::FC_WRITE_MANY) ?
                                          8'd6 : 8'd5)) begin
                        r_tx[1] <= mhrs_pkg::EXC_VALUE;
                    end else if (w_fc == mhrs_pkg::FC_WRITE_ONE) begin
                        if (w_start >= 16'(REG_COUNT)) begin
                            r_tx[1] <= mhrs_pkg::EXC_ADDRESS;
                        end else begin
                            r_tx[0] <= w_fc;
                            r_tx[1] <= r_hdr[1]; r_tx[2] <= r_hdr[2];
                            r_tx[3] <= r_hdr[3]; r_tx[4] <= r_hdr[4];
                            r_txn <= 3'd5;
                            r_st <= S_WRW;
                        end
                    end else if (w_fc == mhrs_pkg::FC_WRITE_MANY) begin
                        if (w_count < 16'd1 || w_count > mhrs_pkg::WRITE_MAX ||
                            {8'd0, r_hdr[5]} != {w_count[14:0], 1'b0} ||
                            {1'b0, r_len} < 9'd6 + {1'b0, r_hdr[5]}) begin
                            r_tx[1] <= mhrs_pkg::EXC_VALUE;
                        end else if (w_end > 17'(REG_COUNT)) begin
                            r_tx[1] <= mhrs_pkg::EXC_ADDRESS;
                        end else begin
                            r_tx[0] <= w_fc;
                            r_tx[1] <= r_hdr[1]; r_tx[2] <= r_hdr[2];
                            r_tx[3] <= r_hdr[3]; r_tx[4] <= r_hdr[4];
                            r_txn <= 3'd5;
                            r_st <= S_WRD;
                        end
                    end else begin
                        if (w_count < 16'd1 || w_count > mhrs_pkg::READ_MAX) begin
                            r_tx[1] <= mhrs_pkg::EXC_VALUE;
                        end else if (w_end > 17'(REG_COUNT)) begin
                            r_tx[1] <= mhrs_pkg::EXC_ADDRESS;
                        end else begin
                            r_tx[0] <= w_fc;
                            r_tx[1] <= {w_count[6:0], 1'b0};
                            r_txn <= 3'd2;
                        end
                    end
                end
                S_WRD: r_st <= S_WRL;
                S_WRL: begin
                    r_lo_byte <= w_buf_rd;
                    r_st <= S_WRW;
                end
                S_WRW: begin
                    if (w_fc == mhrs_pkg::FC_WRITE_ONE) begin
                        r_st <= S_EMIT;
                    end else if (16'(r_idx) + 16'd1 == w_count) begin
                        r_idx <= '0;
                        r_st <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                        r_st <= S_WRD;
                    end
                end
                S_EMIT: begin
                    // header part of the reply, then read data if any
                    if (r_txk == r_txn) begin
                        r_idx <= '0;
                        if (r_tx[0] == w_fc && r_txn == 3'd2 && r_len != 8'd0 &&
                            (w_fc == mhrs_pkg::FC_READ_HOLD ||
                             w_fc == mhrs_pkg::FC_READ_INPUT)) begin
                            r_st <= S_RDR;
                        end else begin
                            r_st <= S_INC;
                        end
                    end else if (w_out_free) begin
                        if (r_reply) begin
                            r_mv <= 1'b1;
                            r_md <= r_tx[r_txk];
                            r_ml <= (r_txk + 3'd1 == r_txn) &&
                                    !(r_tx[0] == w_fc && r_txn == 3'd2 &&
                                      (w_fc == mhrs_pkg::FC_READ_HOLD ||
                                       w_fc == mhrs_pkg::FC_READ_INPUT));
                        end
                        r_txk <= r_txk + 3'd1;
                    end
                end
                S_RDR: begin
                    r_rd_last <= (16'(r_idx) + 16'd1 == w_count);
                    r_st <= S_RDH;
                end
                S_RDH: begin
                    if (w_out_free) begin
                        if (r_reply) begin
                            r_mv <= 1'b1;
                            r_md <= w_bank_rd[15:8];
                            r_ml <= 1'b0;
                        end
                        r_lo_byte <= w_bank_rd[7:0];
                        r_st <= S_RDL;
                    end
                end
                S_RDL: begin
                    if (w_out_free) begin
                        if (r_reply) begin
                            r_mv <= 1'b1;
                            r_md <= r_lo_byte;
                            r_ml <= r_rd_last;
                        end
                        if (r_rd_last) begin
                            r_st <= S_INC;
                        end else begin
                            r_idx <= r_idx + 8'd1;
                            r_st <= S_RDR;
                        end
                    end
                end
                S_INC:  r_st <= S_INCW;
                S_INCW: begin
                    r_len <= '0;
                    r_st  <= S_UPT;
                end
                S_UPT:  r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {r_md, r_own};
    assign m_axis_tlast  = r_ml;

    logic w_unused;
    assign w_unused = ^{s_axis_tdata[23:17]};
endmodule
`default_nettype wire

// ===== src/mhrs_checker.sv =====
// port-level checker for the holding register server, bound to the top
`default_nettype none
`include "modbus_holding_register_server_assert.svh"
module mhrs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tlast,
    input wire        s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    `MHRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "reply byte changed while stalled")
    `MHRS_ASSERT_IMPL(a_addr_nz, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[7:0] != 8'd0, "reply with address zero")
    `MHRS_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser), !s_axis_tready, "input taken right after a frame end or tick")
endmodule

bind modbus_holding_register_server mhrs_checker u_mhrs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
